>>> hw/rtl/smu_pkg.sv
// smu_pkg: shared codes, defaults and types of the stack machine execute unit
// used by smu_muldiv, the top level and smu_checker; depends on nothing
`timescale 1ns / 1ps
package smu_pkg;

    localparam int DEF_DATA_DEPTH   = 256;
    localparam int DEF_RETURN_DEPTH = 256;
    localparam int DEF_MEM_WORDS    = 2048;

    localparam logic [4:0] F_PUSH    = 5'd0;
    localparam logic [4:0] F_ADD     = 5'd1;
    localparam logic [4:0] F_SUB     = 5'd2;
    localparam logic [4:0] F_MUL     = 5'd3;
    localparam logic [4:0] F_DIV     = 5'd4;
    localparam logic [4:0] F_LESS    = 5'd5;
    localparam logic [4:0] F_GREATER = 5'd6;
    localparam logic [4:0] F_EQUAL   = 5'd7;
    localparam logic [4:0] F_DUP     = 5'd8;
    localparam logic [4:0] F_SWAP    = 5'd9;
    localparam logic [4:0] F_ROT     = 5'd10;
    localparam logic [4:0] F_NROT    = 5'd11;
    localparam logic [4:0] F_DROP    = 5'd12;
    localparam logic [4:0] F_TO_R    = 5'd13;
    localparam logic [4:0] F_FROM_R  = 5'd14;
    localparam logic [4:0] F_R_COPY  = 5'd15;
    localparam logic [4:0] F_FETCH   = 5'd16;
    localparam logic [4:0] F_STORE   = 5'd17;
    localparam logic [4:0] F_CELLS   = 5'd18;
    localparam logic [4:0] F_PRINT   = 5'd19;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_UNDER = 3'd1;
    localparam logic [2:0] ST_OVER  = 3'd2;
    localparam logic [2:0] ST_DIV0  = 3'd3;
    localparam logic [2:0] ST_ADDR  = 3'd4;

    typedef struct packed {
        logic        start;
        logic        div;
        logic [31:0] a;
        logic [31:0] b;
    } t_md_req;

endpackage

>>> hw/rtl/smu_ram.sv
// smu_ram: generic single write, single read RAM with registered read data
// depends on nothing
`timescale 1ns / 1ps
module smu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> hw/rtl/smu_muldiv.sv
// smu_muldiv: shared iterative unit, shift-add multiply and restoring divide
// one bit per cycle; depends on smu_pkg
`timescale 1ns / 1ps
module smu_muldiv (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  smu_pkg::t_md_req i_req,
    output logic             o_done,
    output logic [31:0]      o_result
);
    import smu_pkg::*;

    typedef enum logic [1:0] {MD_IDLE, MD_RUN, MD_DONE} t_md_state;

    t_md_state   r_state;
    logic [4:0]  r_cnt;
    logic        r_div;
    logic        r_neg;
    logic [31:0] r_a;
    logic [31:0] r_b;
    logic [31:0] r_acc;
    logic [32:0] rem_sh;
    logic [32:0] diff;

    assign rem_sh   = {r_acc, r_a[31]};
    assign diff     = rem_sh - {1'b0, r_b};
    assign o_done   = (r_state == MD_DONE);
    assign o_result = r_div ? (r_neg ? (32'd0 - r_a) : r_a) : r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MD_IDLE;
            r_cnt   <= 5'd0;
        end else begin
            case (r_state)
                MD_IDLE: begin
                    if (i_req.start) begin
                        r_state <= MD_RUN;
                        r_cnt   <= 5'd0;
                        r_div   <= i_req.div;
                        r_acc   <= 32'd0;
                        r_neg   <= i_req.a[31] ^ i_req.b[31];
                        if (i_req.div) begin
                            r_a <= i_req.a[31] ? (32'd0 - i_req.a) : i_req.a;
                            r_b <= i_req.b[31] ? (32'd0 - i_req.b) : i_req.b;
                        end else begin
                            r_a <= i_req.a;
                            r_b <= i_req.b;
                        end
                    end
                end
                MD_RUN: begin
                    if (r_div) begin
                        if (!diff[32]) begin
                            r_acc <= diff[31:0];
                            r_a   <= {r_a[30:0], 1'b1};
                        end else begin
                            r_acc <= rem_sh[31:0];
                            r_a   <= {r_a[30:0], 1'b0};
                        end
                    end else begin
                        if (r_b[0]) begin
                            r_acc <= r_acc + r_a;
                        end
                        r_a <= {r_a[30:0], 1'b0};
                        r_b <= {1'b0, r_b[31:1]};
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_state <= MD_DONE;
                    end
                end
                MD_DONE: begin
                    r_state <= MD_IDLE;
                end
                default: begin
                    r_state <= MD_IDLE;
                end
            endcase
        end
    end
endmodule

>>> hw/rtl/stack_machine_execute_unit.sv
// stack_machine_execute_unit: top level, sequencer, stacks and word memory
// depends on smu_pkg, smu_ram and smu_muldiv
//
// Runs one Forth primitive per input transfer (i_func, i_literal_value) and
// gives one result transfer: new top of stack, stack depths, printed value
// and a status code. Both channels use valid and stall; a transfer happens on
// a clock edge with valid high and stall low.
// One item at a time: o_stall is low only while the sequencer is idle.
// The sequencer reads up to three data stack entries and checks them; an error
// goes straight to the output. Otherwise multiply and divide first run 32 steps
// through the shared unit and fetch reads the word memory; then up to three
// stack entries are written back one at a time before the result is given.
// After reset the word memory is swept to zero, all MEM_WORDS words, and no
// item is taken meanwhile. Stack depths reset to zero.
// A stalled result holds on the output ports until taken; the next input is
// taken only after that.
// Errors (underflow, overflow, divide by zero, bad address) leave all state
// unchanged and only set the status.
`timescale 1ns / 1ps
module stack_machine_execute_unit #(
    parameter int DATA_DEPTH   = smu_pkg::DEF_DATA_DEPTH,
    parameter int RETURN_DEPTH = smu_pkg::DEF_RETURN_DEPTH,
    parameter int MEM_WORDS    = smu_pkg::DEF_MEM_WORDS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [4:0]                        i_func,
    input  logic signed [31:0]                i_literal_value,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [31:0]                o_top_value,
    output logic [$clog2(DATA_DEPTH+1)-1:0]   o_data_count,
    output logic [$clog2(RETURN_DEPTH+1)-1:0] o_return_count,
    output logic signed [31:0]                o_printed_value,
    output logic                              o_printed_valid,
    output logic [2:0]                        o_status
);
    import smu_pkg::*;

    localparam int DCW = $clog2(DATA_DEPTH + 1);
    localparam int DIW = $clog2(DATA_DEPTH);
    localparam int RCW = $clog2(RETURN_DEPTH + 1);
    localparam int RIW = $clog2(RETURN_DEPTH);
    localparam int MIW = $clog2(MEM_WORDS);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_R0, S_R1, S_R2, S_R3, S_CHK, S_MD, S_MEM, S_PLAN, S_WR, S_OUT
    } t_state;

    t_state          r_state;
    logic [MIW-1:0]  r_clr;
    logic [DCW-1:0]  r_dd;
    logic [RCW-1:0]  r_rd;
    logic [4:0]      r_func;
    logic [31:0]     r_lit;
    logic [31:0]     r_t0;
    logic [31:0]     r_t1;
    logic [31:0]     r_t2;
    logic [31:0]     r_r0;
    logic [31:0]     r_res;
    logic [DIW-1:0]  r_wa [3];
    logic [31:0]     r_wv [3];
    logic [1:0]      r_wn;
    logic [1:0]      r_wi;

    logic [DIW-1:0]  d_raddr;
    logic [31:0]     d_rdata;
    logic            d_we;
    logic [RIW-1:0]  rs_raddr;
    logic [31:0]     rs_rdata;
    logic            rs_we;
    logic            m_we;
    logic [MIW-1:0]  m_waddr;
    logic [31:0]     m_wdata;
    logic [31:0]     m_rdata;
    logic [MIW-1:0]  m_idx;
    t_md_req         md_req;
    logic            md_done;
    logic [31:0]     md_result;

    logic [1:0]      need;
    logic            grow;
    logic            addr_ok;
    logic [2:0]      chk_st;
    logic [31:0]     alu;
    logic [DIW-1:0]  dm1;
    logic [DIW-1:0]  dm2;
    logic [DIW-1:0]  dm3;
    logic [DIW-1:0]  d0;

    assign dm1     = DIW'(r_dd - DCW'(1));
    assign dm2     = DIW'(r_dd - DCW'(2));
    assign dm3     = DIW'(r_dd - DCW'(3));
    assign d0      = DIW'(r_dd);
    assign m_idx   = r_t0[MIW+1:2];
    assign addr_ok = (r_t0[31:2] < 30'(MEM_WORDS));

    always_comb begin
        case (r_state)
            S_R1:    d_raddr = dm2;
            S_R2:    d_raddr = dm3;
            default: d_raddr = dm1;
        endcase
        rs_raddr = RIW'(r_rd - RCW'(1));
        d_we    = (r_state == S_WR);
        rs_we   = (r_state == S_PLAN) && (r_func == F_TO_R);
        m_we    = (r_state == S_CLR) || ((r_state == S_PLAN) && (r_func == F_STORE));
        m_waddr = (r_state == S_CLR) ? r_clr : m_idx;
        m_wdata = (r_state == S_CLR) ? 32'd0 : r_t1;
    end

    // stack needs and checks, ALU result and multiply/divide request
    always_comb begin
        need = 2'd0;
        grow = 1'b0;
        case (r_func)
            F_PUSH, F_FROM_R, F_R_COPY: grow = 1'b1;
            F_ADD, F_SUB, F_MUL, F_DIV, F_LESS, F_GREATER, F_EQUAL,
            F_SWAP, F_STORE: need = 2'd2;
            F_DUP: begin
                need = 2'd1;
                grow = 1'b1;
            end
            F_ROT, F_NROT: need = 2'd3;
            F_DROP, F_TO_R, F_FETCH, F_CELLS, F_PRINT: need = 2'd1;
            default: need = 2'd0;
        endcase
        if (r_dd < DCW'(need)) begin
            chk_st = ST_UNDER;
        end else if ((r_func == F_FROM_R || r_func == F_R_COPY) && r_rd == RCW'(0)) begin
            chk_st = ST_UNDER;
        end else if (grow && r_dd >= DCW'(DATA_DEPTH)) begin
            chk_st = ST_OVER;
        end else if (r_func == F_TO_R && r_rd >= RCW'(RETURN_DEPTH)) begin
            chk_st = ST_OVER;
        end else if (r_func == F_DIV && r_t0 == 32'd0) begin
            chk_st = ST_DIV0;
        end else if ((r_func == F_FETCH || r_func == F_STORE) && !addr_ok) begin
            chk_st = ST_ADDR;
        end else begin
            chk_st = ST_OK;
        end
        case (r_func)
            F_ADD:     alu = r_t1 + r_t0;
            F_SUB:     alu = r_t1 - r_t0;
            F_LESS:    alu = {31'd0, $signed(r_t1) < $signed(r_t0)};
            F_GREATER: alu = {31'd0, $signed(r_t0) < $signed(r_t1)};
            F_EQUAL:   alu = {31'd0, r_t1 == r_t0};
            F_CELLS:   alu = {r_t0[29:0], 2'b00};
            default:   alu = r_t0;
        endcase
        md_req.start = (r_state == S_CHK) && (chk_st == ST_OK)
                       && (r_func == F_MUL || r_func == F_DIV);
        md_req.div   = (r_func == F_DIV);
        md_req.a     = r_t1;
        md_req.b     = r_t0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_dd    <= '0;
            r_rd    <= '0;
            o_valid <= 1'b0;
        end else begin
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + MIW'(1);
                    if (r_clr == MIW'(MEM_WORDS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_func  <= i_func;
                        r_lit   <= i_literal_value;
                        r_state <= S_R0;
                    end
                end
                S_R0: r_state <= S_R1;
                S_R1: begin
                    r_t0    <= d_rdata;
                    r_r0    <= rs_rdata;
                    r_state <= S_R2;
                end
                S_R2: begin
                    r_t1    <= d_rdata;
                    r_state <= S_R3;
                end
                S_R3: begin
                    r_t2    <= d_rdata;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    o_status        <= chk_st;
                    o_printed_value <= 32'd0;
                    o_printed_valid <= 1'b0;
                    o_data_count    <= r_dd;
                    o_return_count  <= r_rd;
                    o_top_value     <= (r_dd != DCW'(0)) ? r_t0 : 32'd0;
                    r_res           <= alu;
                    if (chk_st != ST_OK) begin
                        r_state <= S_OUT;
                        o_valid <= 1'b1;
                    end else if (r_func == F_MUL || r_func == F_DIV) begin
                        r_state <= S_MD;
                    end else if (r_func == F_FETCH) begin
                        r_state <= S_MEM;
                    end else begin
                        r_state <= S_PLAN;
                    end
                end
                S_MD: begin
                    if (md_done) begin
                        r_res   <= md_result;
                        r_state <= S_PLAN;
                    end
                end
                S_MEM: begin
                    r_res   <= m_rdata;
                    r_state <= S_PLAN;
                end
                S_PLAN: begin
                    r_wi <= 2'd0;
                    case (r_func)
                        F_PUSH: begin
                            r_wa[0] <= d0; r_wv[0] <= r_lit; r_wn <= 2'd1;
                            o_top_value <= r_lit; r_dd <= r_dd + DCW'(1);
                            o_data_count <= r_dd + DCW'(1);
                        end
                        F_ADD, F_SUB, F_MUL, F_DIV, F_LESS, F_GREATER, F_EQUAL: begin
                            r_wa[0] <= dm2; r_wv[0] <= r_res; r_wn <= 2'd1;
                            o_top_value <= r_res; r_dd <= r_dd - DCW'(1);
                            o_data_count <= r_dd - DCW'(1);
                        end
                        F_DUP: begin
                            r_wa[0] <= d0; r_wv[0] <= r_t0; r_wn <= 2'd1;
                            r_dd <= r_dd + DCW'(1);
                            o_data_count <= r_dd + DCW'(1);
                        end
                        F_SWAP: begin
                            r_wa[0] <= dm1; r_wv[0] <= r_t1;
                            r_wa[1] <= dm2; r_wv[1] <= r_t0; r_wn <= 2'd2;
                            o_top_value <= r_t1;
                        end
                        F_ROT: begin
                            r_wa[0] <= dm3; r_wv[0] <= r_t1;
                            r_wa[1] <= dm2; r_wv[1] <= r_t0;
                            r_wa[2] <= dm1; r_wv[2] <= r_t2; r_wn <= 2'd3;
                            o_top_value <= r_t2;
                        end
                        F_NROT: begin
                            r_wa[0] <= dm3; r_wv[0] <= r_t0;
                            r_wa[1] <= dm2; r_wv[1] <= r_t2;
                            r_wa[2] <= dm1; r_wv[2] <= r_t1; r_wn <= 2'd3;
                            o_top_value <= r_t1;
                        end
                        F_DROP, F_PRINT, F_TO_R: begin
                            r_wn <= 2'd0;
                            r_dd <= r_dd - DCW'(1);
                            o_data_count <= r_dd - DCW'(1);
                            o_top_value <= (r_dd >= DCW'(2)) ? r_t1 : 32'd0;
                            if (r_func == F_PRINT) begin
                                o_printed_value <= r_t0;
                                o_printed_valid <= 1'b1;
                            end
                            if (r_func == F_TO_R) begin
                                r_rd <= r_rd + RCW'(1);
                                o_return_count <= r_rd + RCW'(1);
                            end
                        end
                        F_FROM_R, F_R_COPY: begin
                            r_wa[0] <= d0; r_wv[0] <= r_r0; r_wn <= 2'd1;
                            o_top_value <= r_r0; r_dd <= r_dd + DCW'(1);
                            o_data_count <= r_dd + DCW'(1);
                            if (r_func == F_FROM_R) begin
                                r_rd <= r_rd - RCW'(1);
                                o_return_count <= r_rd - RCW'(1);
                            end
                        end
                        F_FETCH, F_CELLS: begin
                            r_wa[0] <= dm1; r_wv[0] <= r_res; r_wn <= 2'd1;
                            o_top_value <= r_res;
                        end
                        F_STORE: begin
                            r_wn <= 2'd0;
                            r_dd <= r_dd - DCW'(2);
                            o_data_count <= r_dd - DCW'(2);
                            o_top_value <= (r_dd >= DCW'(3)) ? r_t2 : 32'd0;
                        end
                        default: r_wn <= 2'd0;
                    endcase
                    r_state <= S_WR;
                end
                S_WR: begin
                    if (r_wn == 2'd0 || r_wi == r_wn - 2'd1) begin
                        r_state <= S_OUT;
                        o_valid <= 1'b1;
                    end
                    r_wi <= r_wi + 2'd1;
                end
                S_OUT: begin
                    if (!i_stall) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);

    // write-back held off when the primitive leaves the data stack entries alone
    smu_ram #(.WIDTH(32), .DEPTH(DATA_DEPTH)) u_dstack (
        .i_clk   (i_clk),
        .i_we    (d_we && r_wn != 2'd0),
        .i_waddr (r_wa[r_wi]),
        .i_wdata (r_wv[r_wi]),
        .i_raddr (d_raddr),
        .o_rdata (d_rdata)
    );

    smu_ram #(.WIDTH(32), .DEPTH(RETURN_DEPTH)) u_rstack (
        .i_clk   (i_clk),
        .i_we    (rs_we),
        .i_waddr (RIW'(r_rd)),
        .i_wdata (r_t0),
        .i_raddr (rs_raddr),
        .o_rdata (rs_rdata)
    );

    smu_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_wmem (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_raddr (m_idx),
        .o_rdata (m_rdata)
    );

    smu_muldiv u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (md_req),
        .o_done   (md_done),
        .o_result (md_result)
    );
endmodule

>>> hw/rtl/smu_checker.sv
// smu_checker: port-level assertions on the execute unit, bound to the top level
// depends on smu_pkg and stack_machine_execute_unit
`timescale 1ns / 1ps
module smu_checker #(
    parameter int DATA_DEPTH   = smu_pkg::DEF_DATA_DEPTH,
    parameter int RETURN_DEPTH = smu_pkg::DEF_RETURN_DEPTH
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_stall,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic signed [31:0]                o_top_value,
    input logic [$clog2(DATA_DEPTH+1)-1:0]   o_data_count,
    input logic [$clog2(RETURN_DEPTH+1)-1:0] o_return_count,
    input logic signed [31:0]                o_printed_value,
    input logic                              o_printed_valid,
    input logic [2:0]                        o_status
);
    import smu_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_top_value) && $stable(o_status)
            && $stable(o_data_count) && $stable(o_return_count)
            && $stable(o_printed_value) && $stable(o_printed_valid))
        else $error("stalled result changed");

    // one item at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("transfer taken while busy");

    a_print: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_printed_valid |-> o_status == ST_OK)
        else $error("print flagged with error");

    a_pzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_printed_valid |-> o_printed_value == 32'sd0)
        else $error("printed value not zero");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data_count == '0 |-> o_top_value == 32'sd0)
        else $error("empty stack shows a top value");
endmodule

bind stack_machine_execute_unit smu_checker #(
    .DATA_DEPTH   (DATA_DEPTH),
    .RETURN_DEPTH (RETURN_DEPTH)
) u_smu_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_top_value     (o_top_value),
    .o_data_count    (o_data_count),
    .o_return_count  (o_return_count),
    .o_printed_value (o_printed_value),
    .o_printed_valid (o_printed_valid),
    .o_status        (o_status)
);
